FILE: rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, constants and lookup functions of the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int DEF_MAX_NAME_LEN  = 16;
	localparam int DEF_TABLE_ENTRIES = 64;

	localparam logic [5:0] K_ERROR = 6'd0;
	localparam logic [5:0] K_END   = 6'd15;
	localparam logic [5:0] K_DELIM = 6'd16;
	localparam logic [5:0] K_NUM   = 6'd35;
	localparam logic [5:0] K_ID    = 6'd36;
	localparam logic [5:0] K_STR   = 6'd37;

	localparam logic [1:0] E_NONE  = 2'd0;
	localparam logic [1:0] E_CHAR  = 2'd1;
	localparam logic [1:0] E_LONG  = 2'd2;
	localparam logic [1:0] E_FULL  = 2'd3;

	localparam logic [4:0] D_EQEQ  = 5'd0;
	localparam logic [4:0] D_ASSIGN = 5'd9;
	localparam logic [4:0] D_LT    = 5'd10;
	localparam logic [4:0] D_GT    = 5'd11;
	localparam logic [4:0] D_SLASH = 5'd15;
	localparam logic [4:0] D_LE    = 5'd16;
	localparam logic [4:0] D_NE    = 5'd17;
	localparam logic [4:0] D_GE    = 5'd18;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;

	localparam int KW_COUNT = 14;

	typedef enum logic [3:0] {
		SC_IDLE, SC_IDENT, SC_NUM, SC_SLASH, SC_COM, SC_ENDCOM, SC_LGE, SC_NEQ, SC_STR
	} scan_state_t;

	typedef enum logic [2:0] {
		C_IDLE, C_STEP, C_NAME, C_RD, C_CMP, C_INS, C_FLUSH
	} ctrl_state_t;

	typedef enum logic [2:0] {
		NM_NONE, NM_LONG, NM_KW, NM_FOUND, NM_INS
	} name_res_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [31:0] value;
		logic [1:0]  err;
	} tok_t;

	typedef struct packed {
		logic      accept;
		logic      step;
		logic      push_mid;
		logic      push_last;
		logic      e_clr;
		logic      e_inc;
		name_res_t name_res;
	} stt_cmd_t;

	typedef struct packed {
		logic produces;
		logic has_tok;
		logic need_name;
		logic again;
		logic again_q;
		logic too_long;
		logic kw_hit;
		logic cnt_zero;
		logic cmp_hit;
		logic e_last;
		logic hold_vld;
		logic out_free;
	} stt_sts_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// Returns {valid, index} of a one-character delimiter.
	function automatic logic [5:0] single_delim(input logic [7:0] c);
		case (c)
			8'h25: return {1'b1, 5'd1};
			8'h3B: return {1'b1, 5'd2};
			8'h2C: return {1'b1, 5'd3};
			8'h7B: return {1'b1, 5'd4};
			8'h7D: return {1'b1, 5'd5};
			8'h28: return {1'b1, 5'd6};
			8'h29: return {1'b1, 5'd7};
			8'h2B: return {1'b1, 5'd12};
			8'h2D: return {1'b1, 5'd13};
			8'h2A: return {1'b1, 5'd14};
			default: return 6'd0;
		endcase
	endfunction

	function automatic logic [3:0] kw_len(input int k);
		case (k)
			1: return 4'd3;
			2: return 4'd7;
			3: return 4'd4;
			4: return 4'd2;
			5: return 4'd5;
			6: return 4'd3;
			7: return 4'd3;
			8: return 4'd2;
			9: return 4'd7;
			10: return 4'd4;
			11: return 4'd4;
			12: return 4'd6;
			13: return 4'd5;
			14: return 4'd8;
			default: return 4'd0;
		endcase
	endfunction

	function automatic logic [63:0] kw_word(input int k);
		case (k)
			1: return 64'("and");
			2: return 64'("boolean");
			3: return 64'("else");
			4: return 64'("if");
			5: return 64'("false");
			6: return 64'("int");
			7: return 64'("not");
			8: return 64'("or");
			9: return 64'("program");
			10: return 64'("read");
			11: return 64'("true");
			12: return 64'("string");
			13: return 64'("write");
			14: return 64'("continue");
			default: return 64'd0;
		endcase
	endfunction

	// Character i of keyword k, counted from its first letter.
	function automatic logic [7:0] kw_char(input int k, input int i);
		logic [63:0] w;
		int          sh;
		w  = kw_word(k);
		sh = (int'(kw_len(k)) - 1 - i) * 8;
		if (sh < 0) begin
			return 8'd0;
		end
		return w[sh +: 8];
	endfunction

endpackage

FILE: rtl/stt_char_if.sv
// ----------------------------------------------------------------------------
// stt_char_if
// Character channel: one source byte or an end-of-input mark per transfer.
// ----------------------------------------------------------------------------
interface stt_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_input;

	modport source(output valid, output char_code, output end_of_input, input ready);
	modport sink(input valid, input char_code, input end_of_input, output ready);
endinterface

FILE: rtl/stt_token_if.sv
// ----------------------------------------------------------------------------
// stt_token_if
// Token channel: one token, its value, error code and run marker per transfer.
// ----------------------------------------------------------------------------
interface stt_token_if;
	logic        valid;
	logic        ready;
	logic [5:0]  token_kind;
	logic [31:0] token_value;
	logic [1:0]  error_code;
	logic        last_of_run;

	modport source(output valid, output token_kind, output token_value,
		output error_code, output last_of_run, input ready);
	modport sink(input valid, input token_kind, input token_value,
		input error_code, input last_of_run, output ready);
endinterface

FILE: rtl/source_text_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// Lexical scanner that turns a byte stream into keyword, delimiter, number,
// identifier, string, end and error tokens; names go into a bounded table.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  chars    in         char_code[7:0], end_of_input
//  tokens   out        token_kind[5:0], token_value[31:0], error_code[1:0],
//                      last_of_run
//
// A character is transferred, scanned in one or two passes, and its last token
// is released. A second pass that yields a token first moves the earlier token
// to the output register. An ending name is classified as too long, a keyword
// or a table name, which is compared with each entry in turn and inserted if
// none matches and the table has room.
// Reset clears the scanner, the token valid flags and the table count at once.
// A stalled token output holds the sequencer before its next token transfer.
// ----------------------------------------------------------------------------
module source_text_tokenizer_unit #(
	parameter int MAX_NAME_LEN  = stt_pkg::DEF_MAX_NAME_LEN,
	parameter int TABLE_ENTRIES = stt_pkg::DEF_TABLE_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	stt_char_if.sink    chars,
	stt_token_if.source tokens
);

	stt_pkg::stt_cmd_t cmd;
	stt_pkg::stt_sts_t sts;
	stt_pkg::tok_t     out_tok;
	logic              out_last;

	stt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chars.valid),
		.in_ready (chars.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	stt_datapath #(
		.MAX_NAME_LEN  (MAX_NAME_LEN),
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_char   (chars.char_code),
		.in_eoi    (chars.end_of_input),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (tokens.valid),
		.out_ready (tokens.ready),
		.out_tok   (out_tok),
		.out_last  (out_last)
	);

	assign tokens.token_kind  = out_tok.kind;
	assign tokens.token_value = out_tok.value;
	assign tokens.error_code  = out_tok.err;
	assign tokens.last_of_run = out_last;

endmodule

FILE: rtl/stt_datapath.sv
// ----------------------------------------------------------------------------
// stt_datapath
// Scanner state, number accumulator, name buffer, name table memory,
// token hold register and output register.
// ----------------------------------------------------------------------------
module stt_datapath #(
	parameter int MAX_NAME_LEN  = stt_pkg::DEF_MAX_NAME_LEN,
	parameter int TABLE_ENTRIES = stt_pkg::DEF_TABLE_ENTRIES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_char,
	input  logic              in_eoi,
	input  stt_pkg::stt_cmd_t cmd,
	output stt_pkg::stt_sts_t sts,
	output logic              out_valid,
	input  logic              out_ready,
	output stt_pkg::tok_t     out_tok,
	output logic              out_last
);

	localparam int LW = $clog2(MAX_NAME_LEN + 2);
	localparam int BW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int NB = MAX_NAME_LEN * 8;
	localparam int PW = ((MAX_NAME_LEN > 8) ? MAX_NAME_LEN : 8) * 8;
	localparam int MW = NB + LW;

	stt_pkg::scan_state_t st_q, st_d;
	logic [31:0]  acc_q, acc_d;
	logic [LW-1:0] nlen_q, nlen_d;
	logic [7:0]   first_q, first_d;
	logic [7:0]   nbuf_q [MAX_NAME_LEN];
	logic [7:0]   char_q;
	logic         eoi_q;
	logic         again_q;
	logic         name_str_q;
	logic [IW-1:0] e_q;
	logic [CW-1:0] cnt_q;
	stt_pkg::tok_t hold_q;
	logic         hold_vld_q;
	stt_pkg::tok_t out_q;
	logic         out_last_q;
	logic         out_vld_q;
	logic [MW-1:0] mem [TABLE_ENTRIES];
	logic [MW-1:0] rd_q;

	logic          buf_we;
	logic [LW-1:0] buf_idx;
	logic          has_tok, need_name, name_str, again;
	stt_pkg::tok_t tok;
	logic [5:0]    dl;
	logic [4:0]    d2;
	logic [NB-1:0] nflat;
	logic [PW-1:0] npad;
	logic          kw_hit;
	logic [3:0]    kw_idx;
	logic          cmp_hit;
	logic          full;
	logic          out_free;
	stt_pkg::tok_t name_tok;
	logic          load_name;

	always_comb begin
		st_d      = st_q;
		acc_d     = acc_q;
		nlen_d    = nlen_q;
		first_d   = first_q;
		buf_we    = 1'b0;
		buf_idx   = nlen_q;
		has_tok   = 1'b0;
		need_name = 1'b0;
		name_str  = 1'b0;
		again     = 1'b0;
		tok       = '0;
		dl        = stt_pkg::single_delim(char_q);
		d2        = '0;
		case (st_q)
			stt_pkg::SC_IDENT: begin
				if (!eoi_q && (stt_pkg::is_alpha(char_q) || stt_pkg::is_digit(char_q))) begin
					if (nlen_q < LW'(MAX_NAME_LEN)) begin
						buf_we = 1'b1;
						nlen_d = nlen_q + 1'b1;
					end else begin
						nlen_d = LW'(MAX_NAME_LEN + 1);
					end
				end else begin
					st_d      = stt_pkg::SC_IDLE;
					again     = 1'b1;
					need_name = 1'b1;
				end
			end
			stt_pkg::SC_NUM: begin
				if (!eoi_q && stt_pkg::is_digit(char_q)) begin
					acc_d = (acc_q << 3) + (acc_q << 1) + 32'(char_q - stt_pkg::CH_ZERO);
				end else begin
					st_d    = stt_pkg::SC_IDLE;
					again   = 1'b1;
					has_tok = 1'b1;
					tok     = '{stt_pkg::K_NUM, acc_q, stt_pkg::E_NONE};
				end
			end
			stt_pkg::SC_SLASH: begin
				if (!eoi_q && char_q == stt_pkg::CH_STAR) begin
					st_d = stt_pkg::SC_COM;
				end else begin
					st_d    = stt_pkg::SC_IDLE;
					again   = 1'b1;
					has_tok = 1'b1;
					tok     = '{stt_pkg::K_DELIM + 6'(stt_pkg::D_SLASH), 32'(stt_pkg::D_SLASH),
						stt_pkg::E_NONE};
				end
			end
			stt_pkg::SC_COM, stt_pkg::SC_ENDCOM: begin
				if (eoi_q) begin
					st_d    = stt_pkg::SC_IDLE;
					has_tok = 1'b1;
					tok     = '{stt_pkg::K_END, 32'(stt_pkg::K_END), stt_pkg::E_NONE};
				end else if (char_q == stt_pkg::CH_STAR) begin
					st_d = stt_pkg::SC_ENDCOM;
				end else if (st_q == stt_pkg::SC_ENDCOM && char_q == stt_pkg::CH_SLASH) begin
					st_d = stt_pkg::SC_IDLE;
				end else begin
					st_d = stt_pkg::SC_COM;
				end
			end
			stt_pkg::SC_LGE: begin
				st_d    = stt_pkg::SC_IDLE;
				has_tok = 1'b1;
				if (!eoi_q && char_q == stt_pkg::CH_EQ) begin
					d2 = (first_q == stt_pkg::CH_EQ) ? stt_pkg::D_EQEQ :
						(first_q == stt_pkg::CH_LT) ? stt_pkg::D_LE : stt_pkg::D_GE;
				end else begin
					again = 1'b1;
					d2 = (first_q == stt_pkg::CH_EQ) ? stt_pkg::D_ASSIGN :
						(first_q == stt_pkg::CH_LT) ? stt_pkg::D_LT : stt_pkg::D_GT;
				end
				tok = '{stt_pkg::K_DELIM + 6'(d2), 32'(d2), stt_pkg::E_NONE};
			end
			stt_pkg::SC_NEQ: begin
				st_d    = stt_pkg::SC_IDLE;
				has_tok = 1'b1;
				if (!eoi_q && char_q == stt_pkg::CH_EQ) begin
					tok = '{stt_pkg::K_DELIM + 6'(stt_pkg::D_NE), 32'(stt_pkg::D_NE),
						stt_pkg::E_NONE};
				end else begin
					again = 1'b1;
					tok   = '{stt_pkg::K_ERROR, 32'(stt_pkg::CH_BANG), stt_pkg::E_CHAR};
				end
			end
			stt_pkg::SC_STR: begin
				if (eoi_q) begin
					st_d    = stt_pkg::SC_IDLE;
					has_tok = 1'b1;
					tok     = '{stt_pkg::K_END, 32'(stt_pkg::K_END), stt_pkg::E_NONE};
				end else if (char_q == stt_pkg::CH_QUOTE) begin
					st_d      = stt_pkg::SC_IDLE;
					need_name = 1'b1;
					name_str  = 1'b1;
				end else if (nlen_q < LW'(MAX_NAME_LEN)) begin
					buf_we = 1'b1;
					nlen_d = nlen_q + 1'b1;
				end else begin
					nlen_d = LW'(MAX_NAME_LEN + 1);
				end
			end
			default: begin
				st_d = stt_pkg::SC_IDLE;
				if (eoi_q) begin
					has_tok = 1'b1;
					tok     = '{stt_pkg::K_END, 32'(stt_pkg::K_END), stt_pkg::E_NONE};
				end else if (char_q == stt_pkg::CH_SPACE || char_q == stt_pkg::CH_LF ||
					char_q == stt_pkg::CH_CR || char_q == stt_pkg::CH_TAB) begin
					st_d = stt_pkg::SC_IDLE;
				end else if (stt_pkg::is_alpha(char_q)) begin
					buf_we  = 1'b1;
					buf_idx = '0;
					nlen_d  = LW'(1);
					st_d    = stt_pkg::SC_IDENT;
				end else if (stt_pkg::is_digit(char_q)) begin
					acc_d = 32'(char_q - stt_pkg::CH_ZERO);
					st_d  = stt_pkg::SC_NUM;
				end else if (char_q == stt_pkg::CH_SLASH) begin
					st_d = stt_pkg::SC_SLASH;
				end else if (char_q == stt_pkg::CH_LT || char_q == stt_pkg::CH_GT ||
					char_q == stt_pkg::CH_EQ) begin
					first_d = char_q;
					st_d    = stt_pkg::SC_LGE;
				end else if (char_q == stt_pkg::CH_BANG) begin
					st_d = stt_pkg::SC_NEQ;
				end else if (char_q == stt_pkg::CH_QUOTE) begin
					nlen_d = '0;
					st_d   = stt_pkg::SC_STR;
				end else if (dl[5]) begin
					has_tok = 1'b1;
					tok     = '{stt_pkg::K_DELIM + 6'(dl[4:0]), 32'(dl[4:0]), stt_pkg::E_NONE};
				end else begin
					has_tok = 1'b1;
					tok     = '{stt_pkg::K_ERROR, 32'(char_q), stt_pkg::E_CHAR};
				end
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < MAX_NAME_LEN; i++) begin
			nflat[i*8 +: 8] = nbuf_q[i];
		end
		npad = PW'(nflat);
	end

	always_comb begin
		logic m;
		kw_hit = 1'b0;
		kw_idx = '0;
		for (int k = 1; k <= stt_pkg::KW_COUNT; k++) begin
			m = (nlen_q == LW'(stt_pkg::kw_len(k)));
			for (int i = 0; i < 8; i++) begin
				if (i < int'(stt_pkg::kw_len(k)) && npad[i*8 +: 8] != stt_pkg::kw_char(k, i)) begin
					m = 1'b0;
				end
			end
			if (m && !kw_hit) begin
				kw_hit = 1'b1;
				kw_idx = 4'(k);
			end
		end
	end

	always_comb begin
		cmp_hit = (rd_q[MW-1 -: LW] == nlen_q);
		for (int i = 0; i < MAX_NAME_LEN; i++) begin
			if (LW'(i) < nlen_q && rd_q[i*8 +: 8] != nbuf_q[i]) begin
				cmp_hit = 1'b0;
			end
		end
	end

	assign full     = (cnt_q == CW'(TABLE_ENTRIES));
	assign out_free = !out_vld_q || out_ready;

	always_comb begin
		logic [5:0] nk;
		nk        = name_str_q ? stt_pkg::K_STR : stt_pkg::K_ID;
		load_name = 1'b1;
		name_tok  = '0;
		case (cmd.name_res)
			stt_pkg::NM_LONG:  name_tok = '{stt_pkg::K_ERROR, 32'd0, stt_pkg::E_LONG};
			stt_pkg::NM_KW:    name_tok = '{6'(kw_idx), 32'(kw_idx), stt_pkg::E_NONE};
			stt_pkg::NM_FOUND: name_tok = '{nk, 32'(e_q), stt_pkg::E_NONE};
			stt_pkg::NM_INS: begin
				if (full) begin
					name_tok = '{stt_pkg::K_ERROR, 32'd0, stt_pkg::E_FULL};
				end else begin
					name_tok = '{nk, 32'(cnt_q), stt_pkg::E_NONE};
				end
			end
			default: load_name = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= stt_pkg::SC_IDLE;
			acc_q      <= '0;
			nlen_q     <= '0;
			cnt_q      <= '0;
			hold_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cmd.step) begin
				st_q   <= st_d;
				acc_q  <= acc_d;
				nlen_q <= nlen_d;
			end
			if (cmd.name_res == stt_pkg::NM_INS && !full) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.push_mid || cmd.push_last) begin
				hold_vld_q <= 1'b0;
			end else if ((cmd.step && has_tok) || load_name) begin
				hold_vld_q <= 1'b1;
			end
			if (cmd.push_mid || cmd.push_last) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			char_q <= in_char;
			eoi_q  <= in_eoi;
		end
		if (cmd.step) begin
			first_q    <= first_d;
			again_q    <= again;
			name_str_q <= name_str;
			if (has_tok) begin
				hold_q <= tok;
			end
		end
		if (load_name) begin
			hold_q <= name_tok;
		end
		for (int i = 0; i < MAX_NAME_LEN; i++) begin
			if (cmd.step && buf_we && buf_idx == LW'(i)) begin
				nbuf_q[i] <= char_q;
			end
		end
		if (cmd.e_clr) begin
			e_q <= '0;
		end else if (cmd.e_inc) begin
			e_q <= e_q + 1'b1;
		end
		if (cmd.push_mid || cmd.push_last) begin
			out_q      <= hold_q;
			out_last_q <= cmd.push_last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.name_res == stt_pkg::NM_INS && !full) begin
			mem[cnt_q[IW-1:0]] <= {nlen_q, nflat};
		end
		rd_q <= mem[e_q];
	end

	assign sts.produces  = has_tok || need_name;
	assign sts.has_tok   = has_tok;
	assign sts.need_name = need_name;
	assign sts.again     = again;
	assign sts.again_q   = again_q;
	assign sts.too_long  = (nlen_q > LW'(MAX_NAME_LEN));
	assign sts.kw_hit    = kw_hit && !name_str_q;
	assign sts.cnt_zero  = (cnt_q == '0);
	assign sts.cmp_hit   = cmp_hit;
	assign sts.e_last    = (CW'(e_q) + 1'b1 == cnt_q);
	assign sts.hold_vld  = hold_vld_q;
	assign sts.out_free  = out_free;

	assign out_valid = out_vld_q;
	assign out_tok   = out_q;
	assign out_last  = out_last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_ENTRIES))
		else $error("name table count beyond its size");
	a_nlen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nlen_q <= LW'(MAX_NAME_LEN + 1))
		else $error("name length beyond overflow mark");
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.name_res == stt_pkg::NM_INS && !full) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("insertion did not advance the table count");
	a_push_has_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_mid || cmd.push_last) |-> (hold_vld_q && out_free))
		else $error("token pushed without a held token or a free output");

endmodule

FILE: rtl/stt_ctrl.sv
// ----------------------------------------------------------------------------
// stt_ctrl
// Sequencer: accepts a character, runs up to two scan passes, walks the
// name table when a name ends, and releases tokens to the output register.
// ----------------------------------------------------------------------------
module stt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  stt_pkg::stt_sts_t sts,
	output stt_pkg::stt_cmd_t cmd
);

	stt_pkg::ctrl_state_t state_q, state_d;
	logic pass_q, pass_d;
	stt_pkg::ctrl_state_t after_name;
	logic                 after_pass;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stt_pkg::C_IDLE;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
		end
	end

	always_comb begin
		after_name = (sts.again_q && !pass_q) ? stt_pkg::C_STEP : stt_pkg::C_FLUSH;
		after_pass = (sts.again_q && !pass_q) ? 1'b1 : pass_q;
		state_d    = state_q;
		pass_d     = pass_q;
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.name_res = stt_pkg::NM_NONE;
		case (state_q)
			stt_pkg::C_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					pass_d     = 1'b0;
					state_d    = stt_pkg::C_STEP;
				end
			end
			stt_pkg::C_STEP: begin
				if (sts.hold_vld && sts.produces) begin
					cmd.push_mid = sts.out_free;
				end else begin
					cmd.step = 1'b1;
					if (sts.need_name) begin
						state_d = stt_pkg::C_NAME;
					end else if (sts.again && !pass_q) begin
						pass_d = 1'b1;
					end else begin
						state_d = stt_pkg::C_FLUSH;
					end
				end
			end
			stt_pkg::C_NAME: begin
				cmd.e_clr = 1'b1;
				if (sts.too_long) begin
					cmd.name_res = stt_pkg::NM_LONG;
					state_d      = after_name;
					pass_d       = after_pass;
				end else if (sts.kw_hit) begin
					cmd.name_res = stt_pkg::NM_KW;
					state_d      = after_name;
					pass_d       = after_pass;
				end else if (sts.cnt_zero) begin
					state_d = stt_pkg::C_INS;
				end else begin
					state_d = stt_pkg::C_RD;
				end
			end
			stt_pkg::C_RD: begin
				state_d = stt_pkg::C_CMP;
			end
			stt_pkg::C_CMP: begin
				if (sts.cmp_hit) begin
					cmd.name_res = stt_pkg::NM_FOUND;
					state_d      = after_name;
					pass_d       = after_pass;
				end else if (sts.e_last) begin
					state_d = stt_pkg::C_INS;
				end else begin
					cmd.e_inc = 1'b1;
					state_d   = stt_pkg::C_RD;
				end
			end
			stt_pkg::C_INS: begin
				cmd.name_res = stt_pkg::NM_INS;
				state_d      = after_name;
				pass_d       = after_pass;
			end
			stt_pkg::C_FLUSH: begin
				if (!sts.hold_vld) begin
					state_d = stt_pkg::C_IDLE;
				end else if (sts.out_free) begin
					cmd.push_last = 1'b1;
					state_d       = stt_pkg::C_IDLE;
				end
			end
			default: state_d = stt_pkg::C_IDLE;
		endcase
	end

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == stt_pkg::C_IDLE |-> !sts.hold_vld)
		else $error("token left behind at the end of a run");
	a_one_step_per_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && pass_q) |=> !(cmd.step && !pass_q))
		else $error("second pass fell back to the first");
	a_accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == stt_pkg::C_STEP && !pass_q)
		else $error("accepted character did not start a first pass");

endmodule

FILE: verif/source_text_tokenizer_unit_test.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit_test
// Drives character streams into the tokenizer and checks every token against
// a predictor that scans the same stream and keeps its own copy of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module source_text_tokenizer_unit_test;

	localparam int NAME_MAX = stt_pkg::DEF_MAX_NAME_LEN;
	localparam int TBL_MAX  = stt_pkg::DEF_TABLE_ENTRIES;

	typedef struct {
		logic [5:0]  kind;
		logic [31:0] value;
		logic [1:0]  err;
		logic        last;
	} token_t;

	logic clk;
	logic arst_n;
	stt_char_if  chars ();
	stt_token_if tokens ();

	source_text_tokenizer_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars.sink),
		.tokens (tokens.source)
	);

	token_t               expected_tokens[$];
	int                   mismatch_count;
	stt_pkg::scan_state_t scan_st;
	logic [31:0]          num_acc;
	logic [7:0]           name_buf[NAME_MAX];
	int                   name_len;
	logic [7:0]           tbl_chars[TBL_MAX][NAME_MAX];
	int                   tbl_lens[TBL_MAX];
	int                   tbl_count;
	logic [7:0]           lge_first;
	bit                   more_tokens;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic void push_token(input logic [5:0] k, input logic [31:0] v,
		input logic [1:0] e);
		token_t t;
		t.kind = k;
		t.value = v;
		t.err = e;
		t.last = 1'b0;
		expected_tokens.insert(expected_tokens.size(), t);
	endfunction

	function automatic void add_name_char(input logic [7:0] c);
		if (name_len < NAME_MAX) begin
			name_buf[name_len] = c;
			name_len++;
		end else begin
			name_len = NAME_MAX + 1;
		end
	endfunction

	function automatic void close_name(input logic [5:0] kind);
		bit hit;
		if (name_len > NAME_MAX) begin
			push_token(stt_pkg::K_ERROR, 32'd0, stt_pkg::E_LONG);
			return;
		end
		if (kind == stt_pkg::K_ID) begin
			for (int k = 1; k <= stt_pkg::KW_COUNT; k++) begin
				hit = (int'(stt_pkg::kw_len(k)) == name_len);
				for (int i = 0; i < name_len && hit; i++) begin
					if (stt_pkg::kw_char(k, i) != name_buf[i]) hit = 0;
				end
				if (hit) begin
					push_token(6'(k), 32'(k), stt_pkg::E_NONE);
					return;
				end
			end
		end
		for (int e = 0; e < tbl_count; e++) begin
			hit = (tbl_lens[e] == name_len);
			for (int i = 0; i < name_len && hit; i++) begin
				if (tbl_chars[e][i] != name_buf[i]) hit = 0;
			end
			if (hit) begin
				push_token(kind, 32'(e), stt_pkg::E_NONE);
				return;
			end
		end
		if (tbl_count >= TBL_MAX) begin
			push_token(stt_pkg::K_ERROR, 32'd0, stt_pkg::E_FULL);
			return;
		end
		for (int i = 0; i < name_len; i++) tbl_chars[tbl_count][i] = name_buf[i];
		tbl_lens[tbl_count] = name_len;
		push_token(kind, 32'(tbl_count), stt_pkg::E_NONE);
		tbl_count++;
	endfunction

	function automatic bit scan_pass(input logic [7:0] c, input bit eoi);
		logic [5:0] sd;
		logic [4:0] d;
		case (scan_st)
			stt_pkg::SC_IDENT: begin
				if (!eoi && (stt_pkg::is_alpha(c) || stt_pkg::is_digit(c))) begin
					add_name_char(c);
					return 0;
				end
				scan_st = stt_pkg::SC_IDLE;
				close_name(stt_pkg::K_ID);
				return 1;
			end
			stt_pkg::SC_NUM: begin
				if (!eoi && stt_pkg::is_digit(c)) begin
					num_acc = num_acc * 32'd10 + 32'(c - stt_pkg::CH_ZERO);
					return 0;
				end
				scan_st = stt_pkg::SC_IDLE;
				push_token(stt_pkg::K_NUM, num_acc, stt_pkg::E_NONE);
				return 1;
			end
			stt_pkg::SC_SLASH: begin
				if (!eoi && c == stt_pkg::CH_STAR) begin
					scan_st = stt_pkg::SC_COM;
					return 0;
				end
				scan_st = stt_pkg::SC_IDLE;
				push_token(stt_pkg::K_DELIM + 6'(stt_pkg::D_SLASH), 32'(stt_pkg::D_SLASH),
					stt_pkg::E_NONE);
				return 1;
			end
			stt_pkg::SC_COM, stt_pkg::SC_ENDCOM: begin
				if (eoi) begin
					scan_st = stt_pkg::SC_IDLE;
					push_token(stt_pkg::K_END, 32'(stt_pkg::K_END), stt_pkg::E_NONE);
				end else if (c == stt_pkg::CH_STAR) begin
					scan_st = stt_pkg::SC_ENDCOM;
				end else if (scan_st == stt_pkg::SC_ENDCOM && c == stt_pkg::CH_SLASH) begin
					scan_st = stt_pkg::SC_IDLE;
				end else begin
					scan_st = stt_pkg::SC_COM;
				end
				return 0;
			end
			stt_pkg::SC_LGE: begin
				scan_st = stt_pkg::SC_IDLE;
				if (!eoi && c == stt_pkg::CH_EQ) begin
					d = (lge_first == stt_pkg::CH_EQ) ? stt_pkg::D_EQEQ :
						(lge_first == stt_pkg::CH_LT) ? stt_pkg::D_LE : stt_pkg::D_GE;
					push_token(stt_pkg::K_DELIM + 6'(d), 32'(d), stt_pkg::E_NONE);
					return 0;
				end
				d = (lge_first == stt_pkg::CH_EQ) ? stt_pkg::D_ASSIGN :
					(lge_first == stt_pkg::CH_LT) ? stt_pkg::D_LT : stt_pkg::D_GT;
				push_token(stt_pkg::K_DELIM + 6'(d), 32'(d), stt_pkg::E_NONE);
				return 1;
			end
			stt_pkg::SC_NEQ: begin
				scan_st = stt_pkg::SC_IDLE;
				if (!eoi && c == stt_pkg::CH_EQ) begin
					push_token(stt_pkg::K_DELIM + 6'(stt_pkg::D_NE), 32'(stt_pkg::D_NE),
						stt_pkg::E_NONE);
					return 0;
				end
				push_token(stt_pkg::K_ERROR, 32'(stt_pkg::CH_BANG), stt_pkg::E_CHAR);
				return 1;
			end
			stt_pkg::SC_STR: begin
				if (eoi) begin
					scan_st = stt_pkg::SC_IDLE;
					push_token(stt_pkg::K_END, 32'(stt_pkg::K_END), stt_pkg::E_NONE);
				end else if (c == stt_pkg::CH_QUOTE) begin
					scan_st = stt_pkg::SC_IDLE;
					close_name(stt_pkg::K_STR);
				end else begin
					add_name_char(c);
				end
				return 0;
			end
			default: begin
				scan_st = stt_pkg::SC_IDLE;
				if (eoi) begin
					push_token(stt_pkg::K_END, 32'(stt_pkg::K_END), stt_pkg::E_NONE);
				end else if (c == stt_pkg::CH_SPACE || c == stt_pkg::CH_LF ||
					c == stt_pkg::CH_CR || c == stt_pkg::CH_TAB) begin
				end else if (stt_pkg::is_alpha(c)) begin
					name_len = 0;
					add_name_char(c);
					scan_st = stt_pkg::SC_IDENT;
				end else if (stt_pkg::is_digit(c)) begin
					num_acc = 32'(c - stt_pkg::CH_ZERO);
					scan_st = stt_pkg::SC_NUM;
				end else if (c == stt_pkg::CH_SLASH) begin
					scan_st = stt_pkg::SC_SLASH;
				end else if (c == stt_pkg::CH_LT || c == stt_pkg::CH_GT ||
					c == stt_pkg::CH_EQ) begin
					lge_first = c;
					scan_st = stt_pkg::SC_LGE;
				end else if (c == stt_pkg::CH_BANG) begin
					scan_st = stt_pkg::SC_NEQ;
				end else if (c == stt_pkg::CH_QUOTE) begin
					name_len = 0;
					scan_st = stt_pkg::SC_STR;
				end else begin
					sd = stt_pkg::single_delim(c);
					if (sd[5]) push_token(stt_pkg::K_DELIM + 6'(sd[4:0]), 32'(sd[4:0]),
						stt_pkg::E_NONE);
					else push_token(stt_pkg::K_ERROR, 32'(c), stt_pkg::E_CHAR);
				end
				return 0;
			end
		endcase
	endfunction

	function automatic void predict_tokens(input logic [7:0] c, input bit eoi);
		int before_n;
		before_n = expected_tokens.size();
		if (scan_pass(c, eoi)) void'(scan_pass(c, eoi));
		if (expected_tokens.size() > before_n)
			expected_tokens[expected_tokens.size() - 1].last = 1'b1;
	endfunction

	task automatic send_char(input logic [7:0] c, input bit eoi = 1'b0);
		int gap;
		gap = $urandom_range(0, 9);
		if (gap > 0) begin
			chars.valid <= 1'b0;
			chars.char_code <= 8'($urandom);
			chars.end_of_input <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		chars.valid <= 1'b1;
		chars.char_code <= c;
		chars.end_of_input <= eoi;
		@(posedge clk);
		while (!chars.ready) @(posedge clk);
		predict_tokens(c, eoi);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i]);
	endtask

	always @(posedge clk) begin
		token_t t;
		if (arst_n && tokens.valid && tokens.ready) begin
			if (expected_tokens.size() == 0) begin
				report($sformatf("unexpected token kind %0d value %0d",
					tokens.token_kind, tokens.token_value));
			end else begin
				t = expected_tokens.pop_front();
				if (tokens.token_kind !== t.kind)
					report($sformatf("kind %0d, want %0d", tokens.token_kind, t.kind));
				if (tokens.token_value !== t.value)
					report($sformatf("value %0d, want %0d", tokens.token_value, t.value));
				if (tokens.error_code !== t.err)
					report($sformatf("error %0d, want %0d", tokens.error_code, t.err));
				if (tokens.last_of_run !== t.last)
					report($sformatf("last %0b, want %0b", tokens.last_of_run, t.last));
			end
		end
	end

	initial begin
		int gap;
		tokens.ready = 1'b0;
		@(posedge arst_n);
		while (more_tokens) begin
			@(negedge clk);
			gap = $urandom_range(0, 9);
			if (gap > 0) begin
				tokens.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			tokens.ready <= 1'b1;
			@(posedge clk);
			while (!tokens.valid) @(posedge clk);
		end
	end

	task automatic test_keywords_and_delimiters();
		send_text("and boolean else if false int not or program read true string write ");
		send_text("continue %;,{}()+-*/ / <=<>=>==!=!a= = x\"\"\"s q\" 4294967295 99999999999 ");
		send_text("/* c ** x */ /**/ abcdefghijklmnop abcdefghijklmnopq \"abcdefghijklmnopqr\" ");
		send_char(8'h00);
		send_char(8'hFF);
		send_char(8'h7F);
		send_text("id1 12");
		send_char(8'h00, 1'b1);
		send_text("ab");
		send_char(8'h00, 1'b1);
		send_text("/* x");
		send_char(8'h00, 1'b1);
		send_text("\"open");
		send_char(8'h00, 1'b1);
		send_text("<");
		send_char(8'h00, 1'b1);
		send_text("!");
		send_char(8'h00, 1'b1);
	endtask

	task automatic test_random_source();
		string frags[] = '{"x", "y1", "if", "or", "\"st\"", "12", "0", "/*z*/", "<=", "!=",
			">=", "==", "=", "<", ">", "/", ";", "!", " ", "\t", "\n", "\015", "*", "\""};
		string s;
		int    i;
		i = 0;
		while (i < 70) begin
			if ($urandom_range(0, 4) == 0) begin
				send_char(8'($urandom));
				i++;
			end else begin
				s = frags[$urandom_range(0, frags.size() - 1)];
				send_text(s);
				i += s.len();
			end
			if ($urandom_range(0, 40) == 0) begin
				send_char(8'h00, 1'b1);
				i++;
			end
		end
		send_char(8'h00, 1'b1);
	endtask

	task automatic test_table_full();
		int n;
		n = 0;
		while (tbl_count < TBL_MAX) begin
			if (n < 26) send_text($sformatf("%c ", 8'(8'h61 + n)));
			else if (n < 52) send_text($sformatf("%c ", 8'(8'h41 + n - 26)));
			else send_text($sformatf("z%0d ", n));
			n++;
		end
		send_text("\"a\" \"fresh\" b zz ");
		send_char(8'h00, 1'b1);
	endtask

	initial begin
		mismatch_count = 0;
		more_tokens = 1;
		scan_st = stt_pkg::SC_IDLE;
		num_acc = 0;
		name_len = 0;
		tbl_count = 0;
		lge_first = 0;
		arst_n = 1'b0;
		chars.valid = 1'b0;
		chars.char_code = 8'h00;
		chars.end_of_input = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_keywords_and_delimiters();
		test_random_source();
		test_table_full();
		chars.valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (3 * TBL_MAX + 20) @(posedge clk);
		more_tokens = 0;
		if (mismatch_count == 0 && expected_tokens.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
